### rtl/bol_pkg.sv
// Shared definitions for the bounded ordered list block.
// Defines the field widths, operation and status codes and the sequencer states.
// It has no dependencies.
package bol_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 6;
    localparam int IDX_W   = 7;
    localparam int CNT_W   = 7;
    localparam int STAT_W  = 3;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam logic [OP_W-1:0] OP_INSERT       = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND         = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE_VALUE = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE_POS   = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd4;

    // found_index when nothing matched (-1 in seven bits)
    localparam logic [IDX_W-1:0] IDX_NONE = 7'h7F;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_AT,
        S_SCAN,
        S_SHIFT,
        S_RESULT
    } state_t;

endpackage

### rtl/bol_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/bol_agen.sv
// Address generator: maps a list position onto a physical RAM address
// of the circular store, wrapping at DEPTH. No dependencies.
module bol_agen #(
    parameter int DEPTH = 64
) (
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] base,
    input  logic [$clog2(DEPTH + 1)-1:0]                 offset,
    output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ((AW > CW) ? AW : CW) + 1;

    logic [SW-1:0] sum;
    logic [SW-1:0] wrapped;

    // base and offset are both below DEPTH, so one subtract folds the sum
    assign sum     = SW'(base) + SW'(offset);
    assign wrapped = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
    assign addr    = wrapped[AW-1:0];

endmodule

### rtl/bounded_ordered_list.sv
// Top level of the bounded ordered list block.
// Depends on bol_pkg, bol_ram (entry store) and bol_agen (position to address).
//
// Request channel s_*: s_tuser carries the operation code, s_tdata the value and the
//   position. s_tready is high only while the sequencer is idle: one request at a time.
// Result channel m_*: one result transaction per request with the value taken out, the
//   first matching position, the entry count after the request, and the status in m_tuser.
// The list lives in a circular RAM with a head pointer, so insert and remove at the front
//   never move entries. Find walks the entries one per cycle through the shared compare;
//   removal from the middle closes the gap one moved entry per cycle.
// Steps per request: insert, error cases and unused codes go straight to the result;
//   remove front first reads the front entry; find scans the entries up to the first match;
//   remove value scans to the match, then moves each later entry down; delete position
//   reads the entry at that position, then moves each later entry down. One RAM read port.
// Overlap: the next request is taken at the edge its predecessor's result is, while
//   m_tready stays high; a request is not taken while another is in the sequencer.
// Reset clears the count and head pointer: the list is empty at once; the RAM is not
//   cleared (only positions below the count are ever read).
// Stall: a result waits in the output register while m_tready is low; a new request is
//   accepted meanwhile and its result holds in the sequencer until the register frees.
module bounded_ordered_list #(
    parameter int DEPTH      = bol_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bol_pkg::DATA_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bol_pkg::S_TDATA_W-1:0]  s_tdata,  // value[31:0], position[37:32], zero[39:38]
    input  logic [bol_pkg::OP_W-1:0]       s_tuser,  // op[2:0]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bol_pkg::M_TDATA_W-1:0]  m_tdata,  // result_value[31:0], found_index[38:32],
                                                     // count[45:39], zero[47:46]
    output logic [bol_pkg::STAT_W-1:0]     m_tuser   // status[2:0]
);

    import bol_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    // request fields
    logic signed [VALUE_W-1:0] in_value;
    logic [POS_W-1:0]          in_pos;
    logic [OP_W-1:0]           in_op;

    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_pos   = s_tdata[VALUE_W+POS_W-1:VALUE_W];
    assign in_op    = s_tuser;

    // sequencer and working registers
    state_t state_reg, state_next;

    logic [AW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;
    logic [VALUE_W-1:0]    rv_reg, rv_next;
    logic [IDX_W-1:0]      fi_reg, fi_next;
    logic [STAT_W-1:0]     st_reg, st_next;
    logic [CW-1:0]         rd_idx_reg, rd_idx_next;    // next list position to read
    logic [CW-1:0]         cmp_idx_reg, cmp_idx_next;  // position of the data now on rdata
    logic                  rd_pend_reg, rd_pend_next;  // rdata holds a fresh read
    logic [AW-1:0]         rd_addr_q_reg, rd_addr_q_next;
    logic [AW-1:0]         dst_reg, dst_next;          // slot that takes the next moved entry

    // output register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [VALUE_W-1:0]    m_value_reg, m_value_next;
    logic [IDX_W-1:0]      m_index_reg, m_index_next;
    logic [CNT_W-1:0]      m_count_reg, m_count_next;
    logic [STAT_W-1:0]     m_status_reg, m_status_next;

    // RAM and address generator
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [CW-1:0]         agen_idx;

    // status terms
    logic accept;
    logic is_empty;
    logic is_full;
    logic pos_bad;
    logic hit;
    logic more;
    logic out_free;
    logic [AW-1:0] head_m1;
    logic [AW-1:0] head_p1;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(DEPTH));
    assign pos_bad  = (PW'(in_pos) >= PW'(count_reg));
    // the shared compare: stored entry against the search key
    assign hit      = rd_pend_reg && (ram_rdata == key_reg);
    assign more     = (rd_idx_reg < count_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    assign head_m1 = (head_reg == '0) ? AW'(DEPTH - 1) : (head_reg - AW'(1));
    assign head_p1 = (head_reg == AW'(DEPTH - 1)) ? '0 : (head_reg + AW'(1));

    // read position: at accept the requested one for delete position, else the front; later the walk pointer
    assign agen_idx = (state_reg == S_IDLE)
                    ? ((in_op == OP_DELETE_POS) ? CW'(in_pos) : '0)
                    : rd_idx_reg;

    bol_agen #(
        .DEPTH (DEPTH)
    ) u_agen (
        .base   (head_reg),
        .offset (agen_idx),
        .addr   (ram_raddr)
    );

    bol_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_op)
                        OP_INSERT:
                        begin
                            state_next = S_RESULT;
                        end
                        OP_REMOVE_FRONT:
                        begin
                            state_next = is_empty ? S_RESULT : S_READ_AT;
                        end
                        OP_FIND, OP_REMOVE_VALUE:
                        begin
                            state_next = is_empty ? S_RESULT : S_SCAN;
                        end
                        OP_DELETE_POS:
                        begin
                            state_next = (is_empty || pos_bad) ? S_RESULT : S_READ_AT;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_READ_AT:
            begin
                state_next = (op_reg == OP_REMOVE_FRONT) ? S_RESULT : S_SHIFT;
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = (op_reg == OP_FIND) ? S_RESULT : S_SHIFT;
                end
                else if (!more)
                begin
                    state_next = S_RESULT;
                end
            end
            S_SHIFT:
            begin
                if (!rd_pend_reg && !more)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        rv_next        = rv_reg;
        fi_next        = fi_reg;
        st_next        = st_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        rd_pend_next   = rd_pend_reg;
        rd_addr_q_next = rd_addr_q_reg;
        dst_next       = dst_reg;

        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_value_next   = m_value_reg;
        m_index_next   = m_index_reg;
        m_count_next   = m_count_reg;
        m_status_next  = m_status_reg;

        ram_we    = 1'b0;
        ram_waddr = dst_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = in_op;
                    key_next     = DATA_WIDTH'(in_value);
                    rv_next      = '0;
                    fi_next      = IDX_NONE;
                    st_next      = STAT_OK;
                    rd_pend_next = 1'b0;
                    rd_idx_next  = '0;
                    case (in_op)
                        OP_INSERT:
                        begin
                            if (is_full)
                            begin
                                st_next = STAT_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = head_m1;
                                ram_wdata  = DATA_WIDTH'(in_value);
                                head_next  = head_m1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_REMOVE_FRONT:
                        begin
                            if (is_empty)
                            begin
                                st_next = STAT_EMPTY;
                            end
                            else
                            begin
                                ram_re = 1'b1;
                            end
                        end
                        OP_FIND, OP_REMOVE_VALUE:
                        begin
                            if (is_empty)
                            begin
                                st_next = STAT_EMPTY;
                            end
                        end
                        OP_DELETE_POS:
                        begin
                            if (is_empty)
                            begin
                                st_next = STAT_EMPTY;
                            end
                            else if (pos_bad)
                            begin
                                st_next = STAT_BADPOS;
                            end
                            else
                            begin
                                ram_re         = 1'b1;
                                rd_addr_q_next = ram_raddr;
                                rd_idx_next    = CW'(in_pos) + CW'(1);
                            end
                        end
                        default:
                        begin
                            st_next = STAT_OK;
                        end
                    endcase
                end
            end
            S_READ_AT:
            begin
                rv_next = VALUE_W'(ram_rdata);
                if (op_reg == OP_REMOVE_FRONT)
                begin
                    // drop the front by advancing the head
                    head_next  = head_p1;
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    dst_next     = rd_addr_q_reg;
                    rd_pend_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    fi_next = IDX_W'(cmp_idx_reg);
                    if (op_reg == OP_REMOVE_VALUE)
                    begin
                        rv_next      = VALUE_W'(ram_rdata);
                        dst_next     = rd_addr_q_reg;
                        rd_idx_next  = cmp_idx_reg + CW'(1);
                        rd_pend_next = 1'b0;
                    end
                end
                else if (more)
                begin
                    ram_re         = 1'b1;
                    rd_addr_q_next = ram_raddr;
                    cmp_idx_next   = rd_idx_reg;
                    rd_idx_next    = rd_idx_reg + CW'(1);
                    rd_pend_next   = 1'b1;
                end
                else
                begin
                    st_next      = STAT_NOTFOUND;
                    rd_pend_next = 1'b0;
                end
            end
            S_SHIFT:
            begin
                // move the entry read last cycle down one slot
                if (rd_pend_reg)
                begin
                    ram_we   = 1'b1;
                    dst_next = rd_addr_q_reg;
                end
                if (more)
                begin
                    ram_re         = 1'b1;
                    rd_addr_q_next = ram_raddr;
                    rd_idx_next    = rd_idx_reg + CW'(1);
                    rd_pend_next   = 1'b1;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_value_next  = rv_reg;
                    m_index_next  = fi_reg;
                    m_count_next  = CNT_W'(count_reg);
                    m_status_next = st_reg;
                end
            end
            default:
            begin
                rd_pend_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            rd_pend_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            rd_pend_reg  <= rd_pend_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        rv_reg        <= rv_next;
        fi_reg        <= fi_next;
        st_reg        <= st_next;
        rd_idx_reg    <= rd_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        rd_addr_q_reg <= rd_addr_q_next;
        dst_reg       <= dst_next;
        m_value_reg   <= m_value_next;
        m_index_reg   <= m_index_next;
        m_count_reg   <= m_count_next;
        m_status_reg  <= m_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - IDX_W - CNT_W){1'b0}},
                       m_count_reg, m_index_reg, m_value_reg};
    assign m_tuser  = m_status_reg;

    // the count never runs past the capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond capacity");

    // the count moves by at most one per cycle
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CW'(1)) ||
             (count_reg + CW'(1) == $past(count_reg))))
        else $error("entry count jumped");

    // a move never reads the slot it writes in the same cycle
    a_ram_ports: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("RAM read and write collide");

    // a full status only reports a full list
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && (m_status_reg == STAT_FULL)) |-> (m_count_reg == CNT_W'(DEPTH)))
        else $error("full status with room left");

endmodule
